>>> sv/assert_macros.svh
// assertion macros used by the rtl top
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property holds in the same cycle
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// property holds in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

>>> sv/sem_pkg.sv
// types and constants of the sobel edge magnitude block
// no dependencies
`default_nettype none
package sem_pkg;
  localparam int PIX_W = 8;
  localparam int CH_N = 3;
  localparam int DIM_W = 11;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'd1;
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;
  localparam logic [DIM_W-1:0] DIM_RESET = 11'd1024;
  localparam logic [PIX_W-1:0] MAG_MAX = 8'd255;
  localparam logic [16:0] ROUND_LIMIT = 17'd65280;
  typedef logic [CH_N*PIX_W-1:0] rgb_t;
  typedef logic [8:0][PIX_W-1:0] tap_t;
endpackage
`default_nettype wire

>>> sv/sem_in_if.sv
// input pixel channel
// depends on sem_pkg
`default_nettype none
interface sem_in_if import sem_pkg::*; ();
  logic valid;
  logic ready;
  logic operation;
  logic [PIX_W-1:0] red;
  logic [PIX_W-1:0] green;
  logic [PIX_W-1:0] blue;
  modport source (output valid, operation, red, green, blue, input ready);
  modport sink (input valid, operation, red, green, blue, output ready);
endinterface
`default_nettype wire

>>> sv/sem_out_if.sv
// result channel
// depends on sem_pkg
`default_nettype none
interface sem_out_if import sem_pkg::*; ();
  logic valid;
  logic ready;
  logic [PIX_W-1:0] edge_red;
  logic [PIX_W-1:0] edge_green;
  logic [PIX_W-1:0] edge_blue;
  logic frame_end;
  modport source (output valid, edge_red, edge_green, edge_blue, frame_end, input ready);
  modport sink (input valid, edge_red, edge_green, edge_blue, frame_end, output ready);
endinterface
`default_nettype wire

>>> sv/sem_cfg_if.sv
// configuration write channel
// depends on sem_pkg
`default_nettype none
interface sem_cfg_if import sem_pkg::*; ();
  logic valid;
  logic ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DIM_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> sv/sem_lane.sv
// one channel lane: sobel gradients, squared magnitude, bit-serial rounded root
// depends on sem_pkg
`default_nettype none
module sem_lane import sem_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire tap_t             taps,
  output logic                  done,
  output logic [PIX_W-1:0]      mag
);
  typedef enum logic [2:0] {L_IDLE, L_SQ, L_ROOT, L_ROUND} lstate_t;
  lstate_t state_r;
  logic signed [10:0] gx_r, gy_r;
  logic [20:0] n_r;
  logic [7:0] root_r;
  logic [2:0] step_r;
  logic done_r;
  logic [7:0] mag_r;
  logic signed [10:0] gx_c, gy_c;
  logic [7:0] trial;
  logic [15:0] trial_sq;
  logic [16:0] kk;

  always_comb begin
    gx_c = 11'(taps[2]) + 11'({taps[5], 1'b0}) + 11'(taps[8])
         - 11'(taps[0]) - 11'({taps[3], 1'b0}) - 11'(taps[6]);
    gy_c = 11'(taps[6]) + 11'({taps[7], 1'b0}) + 11'(taps[8])
         - 11'(taps[0]) - 11'({taps[1], 1'b0}) - 11'(taps[2]);
    trial = root_r | (8'h80 >> step_r);
    trial_sq = {8'b0, trial} * {8'b0, trial};
    kk = 17'({8'b0, root_r} * {8'b0, root_r}) + 17'(root_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= L_IDLE;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        L_IDLE: begin
          if (start) begin
            gx_r <= gx_c;
            gy_r <= gy_c;
            state_r <= L_SQ;
          end
        end
        L_SQ: begin
          n_r <= 21'(gx_r * gx_r) + 21'(gy_r * gy_r);
          root_r <= '0;
          step_r <= '0;
          state_r <= L_ROOT;
        end
        L_ROOT: begin
          if (trial_sq <= n_r[15:0]) begin
            root_r <= trial;
          end
          step_r <= step_r + 3'd1;
          if (step_r == 3'd7) begin
            state_r <= L_ROUND;
          end
        end
        L_ROUND: begin
          if (n_r > 21'(ROUND_LIMIT)) begin
            mag_r <= MAG_MAX;
          end else begin
            mag_r <= root_r + 8'((21'(kk) < n_r) ? 1 : 0);
          end
          done_r <= 1'b1;
          state_r <= L_IDLE;
        end
        default: state_r <= L_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign mag = mag_r;
endmodule
`default_nettype wire

>>> sv/sobel_edge_magnitude_rgb.sv
// an accepted item is registered in S_READ; the lanes then run L_SQ, the 8-step bit-serial root
// in L_ROOT and L_ROUND; S_OUT loads the output register, and only then is a new item taken
// items without a result end in S_READ; a result waiting at the output holds the next one
// rst_n synchronous active low: frame size 1024x1024, position and window cleared
// row buffers are not cleared; a config write restarts the frame
`default_nettype none
`include "assert_macros.svh"
module sobel_edge_magnitude_rgb import sem_pkg::*; #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic clk,
  input  wire logic rst_n,
  sem_in_if.sink    in_ch,
  sem_out_if.source out_ch,
  sem_cfg_if.sink   cfg_ch
);
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 2);

  typedef enum logic [1:0] {S_IDLE, S_READ, S_RUN, S_OUT} state_t;
  state_t state_r;

  logic [DIM_W-1:0] frame_width_r, frame_height_r;
  logic [CW-1:0] col_r, pos_c_r;
  logic [RW-1:0] row_r, pos_r_r;
  logic [2:0][2:0][CH_N*PIX_W-1:0] win_r;
  rgb_t pix_r, above_rd_r, two_rd_r;
  logic vld_r, fend_r, c0_r;
  rgb_t above_mem [MAX_WIDTH];
  rgb_t two_mem [MAX_WIDTH];
  logic out_valid_r, frame_end_r;
  logic [CH_N-1:0][PIX_W-1:0] edge_r;

  logic [WW-1:0] w_eff;
  logic [RW-1:0] h_eff;
  logic [CW-1:0] c_norm;
  logic [RW-1:0] r_norm;
  logic accept, cfg_wr;
  logic [2:0][CH_N*PIX_W-1:0] colv;
  logic [2:0][2:0][CH_N*PIX_W-1:0] sh;
  logic [2:0][2:0][CH_N*PIX_W-1:0] win_nxt;
  tap_t [CH_N-1:0] taps;
  logic [CH_N-1:0] lane_done;
  logic [CH_N-1:0][PIX_W-1:0] lane_mag;
  logic lane_start;

  assign accept = in_ch.valid && in_ch.ready;
  assign cfg_wr = cfg_ch.valid && cfg_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE) && !cfg_ch.valid;
  assign cfg_ch.ready = (state_r == S_IDLE);

  always_comb begin
    if (frame_width_r == '0) w_eff = WW'(1);
    else if (32'(frame_width_r) > 32'(MAX_WIDTH)) w_eff = WW'(MAX_WIDTH);
    else w_eff = WW'(frame_width_r);
    if (frame_height_r == '0) h_eff = RW'(1);
    else if (32'(frame_height_r) > 32'(MAX_HEIGHT)) h_eff = RW'(MAX_HEIGHT);
    else h_eff = RW'(frame_height_r);
    if (32'(col_r) >= 32'(w_eff) || 32'(row_r) > 32'(h_eff) + 32'd1
        || (32'(row_r) == 32'(h_eff) + 32'd1 && col_r != '0)) begin
      c_norm = '0;
      r_norm = '0;
    end else begin
      c_norm = col_r;
      r_norm = row_r;
    end
  end

  // column entering the window, top to bottom
  always_comb begin
    colv[0] = (32'(pos_r_r) >= 32'd2) ? two_rd_r : '0;
    colv[1] = (32'(pos_r_r) >= 32'd1) ? above_rd_r : '0;
    colv[2] = pix_r;
    for (int k = 0; k < 3; k++) begin
      sh[k][0] = win_r[k][1];
      sh[k][1] = win_r[k][2];
      sh[k][2] = c0_r ? '0 : colv[k];
    end
    // a new row starts with only the entering column
    for (int k = 0; k < 3; k++) begin
      win_nxt[k][0] = c0_r ? '0 : sh[k][0];
      win_nxt[k][1] = c0_r ? '0 : sh[k][1];
      win_nxt[k][2] = colv[k];
    end
    for (int ch = 0; ch < CH_N; ch++) begin
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          taps[ch][k*3+j] = sh[k][j][(CH_N-1-ch)*PIX_W +: PIX_W];
        end
      end
    end
  end

  assign lane_start = (state_r == S_READ) && vld_r;

  for (genvar g = 0; g < CH_N; g++) begin : g_lane
    sem_lane u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .start (lane_start),
      .taps  (taps[g]),
      .done  (lane_done[g]),
      .mag   (lane_mag[g])
    );
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      above_rd_r <= above_mem[c_norm];
      two_rd_r <= two_mem[c_norm];
    end
    if (state_r == S_READ) begin
      two_mem[pos_c_r] <= above_rd_r;
      above_mem[pos_c_r] <= pix_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      frame_width_r <= DIM_RESET;
      frame_height_r <= DIM_RESET;
      col_r <= '0;
      row_r <= '0;
      win_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == S_OUT && (!out_valid_r || out_ch.ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (cfg_wr) begin
            if (cfg_ch.index == CFG_FRAME_WIDTH) frame_width_r <= cfg_ch.data;
            if (cfg_ch.index == CFG_FRAME_HEIGHT) frame_height_r <= cfg_ch.data;
            col_r <= '0;
            row_r <= '0;
            win_r <= '0;
          end else if (accept) begin
            pos_c_r <= c_norm;
            pos_r_r <= r_norm;
            pix_r <= (in_ch.operation == OP_PIXEL && r_norm < h_eff)
                     ? {in_ch.red, in_ch.green, in_ch.blue} : '0;
            c0_r <= (c_norm == '0);
            vld_r <= (c_norm == '0) ? (32'(r_norm) >= 32'd2) : (r_norm != '0);
            fend_r <= (c_norm == '0) && (32'(r_norm) == 32'(h_eff) + 32'd1);
            if (32'(r_norm) == 32'(h_eff) + 32'd1) begin
              col_r <= '0;
              row_r <= '0;
            end else if (32'(c_norm) + 32'd1 >= 32'(w_eff)) begin
              col_r <= '0;
              row_r <= r_norm + RW'(1);
            end else begin
              col_r <= c_norm + CW'(1);
              row_r <= r_norm;
            end
            state_r <= S_READ;
          end
        end
        S_READ: begin
          win_r <= win_nxt;
          state_r <= vld_r ? S_RUN : S_IDLE;
        end
        S_RUN: begin
          if (lane_done[0]) begin
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_ch.ready) begin
            edge_r <= lane_mag;
            frame_end_r <= fend_r;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.edge_red = edge_r[0];
  assign out_ch.edge_green = edge_r[1];
  assign out_ch.edge_blue = edge_r[2];
  assign out_ch.frame_end = frame_end_r;

  `ASSERT_SAME(a_lanes_lockstep, 1'b1, lane_done == '0 || lane_done == '1, "lanes out of step")
  `ASSERT_NEXT(a_one_item, accept, !in_ch.ready, "item taken while busy")
  `ASSERT_NEXT(a_out_from_merge, !out_valid_r, !out_valid_r || $past(state_r == S_OUT),
    "result without merge")
  `ASSERT_SAME(a_start_idle_lane, lane_start, state_r == S_READ && vld_r, "lane start misfired")
endmodule
`default_nettype wire

>>> test/tb_sobel_edge_magnitude_rgb.sv
// testbench for the rgb sobel edge magnitude block: random and directed frames
// checked item by item against an internal line-buffer predictor
// depends on sem_pkg, sem_in_if, sem_out_if, sem_cfg_if and the rtl top
`timescale 1ns / 1ps
`default_nettype none
module tb_sobel_edge_magnitude_rgb;
  import sem_pkg::*;

  typedef struct {
    logic op;
    logic [PIX_W-1:0] r, g, b;
  } pixel_item_t;

  typedef struct {
    logic [PIX_W-1:0] mag_r, mag_g, mag_b;
    logic last;
  } edge_mag_t;

  localparam int LINE_MAX = 1024;
  localparam int DRAIN_CYCLES = 40;
  localparam int STALL_LIMIT = 4000;

  logic clk;
  logic rst_n;

  sem_in_if in_if();
  sem_out_if out_if();
  sem_cfg_if cfg_if();

  sobel_edge_magnitude_rgb dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_if), .out_ch(out_if), .cfg_ch(cfg_if)
  );

  pixel_item_t pixel_q[$];
  edge_mag_t mag_q[$];
  int fail_count = 0;
  int idle_pct = 24;
  int stall_cycles = 0;

  // predictor state
  logic [23:0] line_above [LINE_MAX];
  logic [23:0] line_two_above [LINE_MAX];
  logic [23:0] win [3][3];
  logic [DIM_W-1:0] cfg_w, cfg_h;
  int unsigned pos_row, pos_col;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned eff_dim(logic [DIM_W-1:0] v);
    if (v == 0) return 1;
    return (v > LINE_MAX) ? LINE_MAX : v;
  endfunction

  function automatic void restart_frame();
    pos_row = 0;
    pos_col = 0;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) win[i][j] = '0;
  endfunction

  function automatic logic [PIX_W-1:0] channel_mag(int sh);
    int p [3][3];
    int gx, gy;
    int unsigned n, k;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) p[i][j] = (win[i][j] >> sh) & 8'hff;
    gx = p[0][2] - p[0][0] + 2 * (p[1][2] - p[1][0]) + p[2][2] - p[2][0];
    gy = p[2][0] - p[0][0] + 2 * (p[2][1] - p[0][1]) + p[2][2] - p[0][2];
    n = gx * gx + gy * gy;
    k = 0;
    for (int b = 11; b >= 0; b--)
      if ((k | (1 << b)) * (k | (1 << b)) <= n) k = k | (1 << b);
    if (n > k * k + k) k++;
    return (k > MAG_MAX) ? MAG_MAX : k[PIX_W-1:0];
  endfunction

  function automatic bit sobel_step(pixel_item_t it, output edge_mag_t res);
    int unsigned w, h, r, c, orow, ocol;
    logic [23:0] px, top, mid;
    logic [23:0] col [3];
    bit ok;
    w = eff_dim(cfg_w);
    h = eff_dim(cfg_h);
    r = pos_row;
    c = pos_col;
    if (c >= w || r > h + 1 || (r == h + 1 && c != 0)) begin
      r = 0;
      c = 0;
    end
    px = (it.op == OP_PIXEL && r < h) ? {it.r, it.g, it.b} : '0;
    top = (r >= 2) ? line_two_above[c] : '0;
    mid = (r >= 1) ? line_above[c] : '0;
    line_two_above[c] = line_above[c];
    line_above[c] = px;
    col[0] = top;
    col[1] = mid;
    col[2] = px;
    for (int i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
      win[i][2] = (c == 0) ? '0 : col[i];
    end
    ok = (c == 0) ? (r >= 2) : (r >= 1);
    if (ok) begin
      orow = (c == 0) ? r - 2 : r - 1;
      ocol = (c == 0) ? w - 1 : c - 1;
      res.mag_r = channel_mag(16);
      res.mag_g = channel_mag(8);
      res.mag_b = channel_mag(0);
      res.last = (orow == h - 1 && ocol == w - 1);
    end
    if (c == 0) begin
      for (int i = 0; i < 3; i++) begin
        win[i][0] = '0;
        win[i][1] = '0;
        win[i][2] = col[i];
      end
    end
    if (r == h + 1) begin
      r = 0;
      c = 0;
    end else begin
      c++;
      if (c >= w) begin
        c = 0;
        r++;
      end
    end
    pos_row = r;
    pos_col = c;
    return ok;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  // pixel driver
  always @(posedge clk) begin
    pixel_item_t it;
    edge_mag_t res;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        it.op = in_if.operation;
        it.r = in_if.red;
        it.g = in_if.green;
        it.b = in_if.blue;
        if (sobel_step(it, res)) mag_q.push_back(res);
      end
      if (!in_if.valid || in_if.ready) begin
        if (pixel_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
          it = pixel_q.pop_front();
          in_if.valid <= 1'b1;
          in_if.operation <= it.op;
          in_if.red <= it.r;
          in_if.green <= it.g;
          in_if.blue <= it.b;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    edge_mag_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (mag_q.size() == 0) begin
          report_mismatch("unexpected item", 1, 0);
        end else begin
          want = mag_q.pop_front();
          if (out_if.edge_red !== want.mag_r)
            report_mismatch("edge_red", out_if.edge_red, want.mag_r);
          if (out_if.edge_green !== want.mag_g)
            report_mismatch("edge_green", out_if.edge_green, want.mag_g);
          if (out_if.edge_blue !== want.mag_b)
            report_mismatch("edge_blue", out_if.edge_blue, want.mag_b);
          if (out_if.frame_end !== want.last)
            report_mismatch("frame_end", out_if.frame_end, want.last);
        end
      end
      out_if.ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("[sobel_edge_magnitude_rgb] ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic wait_drained();
    wait (pixel_q.size() == 0 && !in_if.valid && mag_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= val;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    if (idx == CFG_FRAME_WIDTH) cfg_w = val;
    else cfg_h = val;
    restart_frame();
  endtask

  task automatic set_frame(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
    wait_drained();
    write_reg(CFG_FRAME_WIDTH, w);
    write_reg(CFG_FRAME_HEIGHT, h);
  endtask

  function automatic logic [PIX_W-1:0] rand_chan();
    case ($urandom_range(7))
      0: return '0;
      1: return MAG_MAX;
      default: return PIX_W'($urandom_range(255));
    endcase
  endfunction

  // one frame of pixels plus its flush items; noise flips the operation now and then
  function automatic int push_frame(int mode, int noise_pct);
    int unsigned w, h, n;
    pixel_item_t it;
    w = eff_dim(cfg_w);
    h = eff_dim(cfg_h);
    n = h * w + w + 1;
    for (int unsigned i = 0; i < n; i++) begin
      it.op = (i < h * w) ? OP_PIXEL : OP_FLUSH;
      if ($urandom_range(99) < noise_pct) it.op = ~it.op;
      case (mode)
        1: {it.r, it.g, it.b} = ((i + i / w) % 2) ? 24'hffffff : 24'h000000;
        2: {it.r, it.g, it.b} = (i % w < w / 2) ? 24'hff00ff : 24'h00ff00;
        default: begin
          it.r = rand_chan();
          it.g = rand_chan();
          it.b = rand_chan();
        end
      endcase
      pixel_q.push_back(it);
    end
    return n;
  endfunction

  initial begin
    int sent;
    int phase;
    pixel_item_t it;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.operation = OP_PIXEL;
    in_if.red = '0;
    in_if.green = '0;
    in_if.blue = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_FRAME_WIDTH;
    cfg_if.data = '0;
    cfg_w = DIM_RESET;
    cfg_h = DIM_RESET;
    restart_frame();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed frames
    set_frame(11'd3, 11'd3);
    void'(push_frame(1, 0));
    void'(push_frame(2, 0));
    set_frame(11'd1, 11'd1);
    void'(push_frame(0, 0));
    set_frame(11'd0, 11'd0);
    void'(push_frame(1, 0));
    set_frame(11'd4, 11'd2);
    it = '{OP_FLUSH, 8'hff, 8'hff, 8'hff};
    pixel_q.push_back(it);
    void'(push_frame(0, 30));
    set_frame(11'd1, 11'd5);
    void'(push_frame(2, 0));

    // random frames
    sent = 0;
    phase = 0;
    while (sent < 640) begin
      set_frame(DIM_W'($urandom_range(12, 1)), DIM_W'($urandom_range(8, 1)));
      idle_pct = (phase == 3) ? 0 : 24;
      if (phase == 5) begin
        sent += push_frame(0, 0);
        wait_drained();
      end
      sent += push_frame(0, ($urandom_range(3) == 0) ? 5 : 0);
      if ($urandom_range(3) == 0) sent += push_frame(0, 0);
      phase++;
    end
    wait_drained();

    if (fail_count == 0) begin
      $display("[sobel_edge_magnitude_rgb] OK");
    end else begin
      $display("[sobel_edge_magnitude_rgb] ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
